// File: hw/rtl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the software timer table
// Field widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int OP_W     = 3;
   localparam int ID_W     = 4;
   localparam int TICK_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 3'd0,
      OP_DELETE = 3'd1,
      OP_START  = 3'd2,
      OP_STOP   = 3'd3,
      OP_TICK   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_CREATED  = 3'd0,
      STS_FULL     = 3'd1,
      STS_EMPTY    = 3'd2,
      STS_DONE     = 3'd3,
      STS_FIRED    = 3'd4,
      STS_SCAN_END = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_ADDR,
      ST_SCAN_EVAL,
      ST_SCAN_END
   } state_type;

endpackage

// File: hw/rtl/stt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_ifs: request and response channels of the software timer table
// Valid/ready handshake; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface stt_req_if;
   logic                            valid;
   logic                            ready;
   logic [stt_pkg::OP_W-1:0]        operation;
   logic [stt_pkg::ID_W-1:0]        timer_id;
   logic                            timer_kind;
   logic [stt_pkg::TICK_W-1:0]      interval;
   logic [stt_pkg::TICK_W-1:0]      now;

   modport source (output valid, operation, timer_id, timer_kind, interval, now,
                   input ready);
   modport sink   (input valid, operation, timer_id, timer_kind, interval, now,
                   output ready);
endinterface

interface stt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [stt_pkg::STATUS_W-1:0]    status;
   logic [stt_pkg::SLOT_W-1:0]      slot;
   logic                            last;

   modport source (output valid, status, slot, last, input ready);
   modport sink   (input valid, status, slot, last, output ready);
endinterface

// File: hw/rtl/stt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/software_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table: table of one-shot and repeating software timers
// Create, delete, start and stop slots; a tick request scans all slots and
// reports every running slot whose deadline equals the current tick.
// ----------------------------------------------------------------------------
//
//  channel  | dir | fields                                   | per request
//  ---------+-----+------------------------------------------+---------------
//  req_ch   | in  | operation, timer_id, timer_kind,         | one request
//           |     | interval, now                            |
//  rsp_ch   | out | status, slot, last                       | 1 response, or
//           |     |                                          | fires + scan end
//
//  Steps: create/delete/start/stop/unknown are accepted in IDLE, run in EXEC.
//  A tick visits SCAN_ADDR for every slot and SCAN_EVAL for every running
//  slot, then SCAN_END; the scan is serial, set by the single read port of
//  the start/period RAMs and the one shared 32-bit add-and-compare unit.
//  Reset: synchronous; clears slot flags, count, sequencer and response valid.
//  The RAMs need no clearing pass: an entry is only used once it is written.
//  Stalls: the response register holds while rsp_ch.ready is low; the
//  sequencer waits at each response it has to load. A new request is taken
//  in IDLE even while the previous final response waits in the register.
// ----------------------------------------------------------------------------
module software_timer_table #(
   parameter int SLOT_COUNT = 16
) (
   input  logic          clock,
   input  logic          reset,
   stt_req_if.sink       req_ch,
   stt_rsp_if.source     rsp_ch
);
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   // sequencer
   stt_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   // captured request
   logic [stt_pkg::OP_W-1:0]   op_ff;
   logic [stt_pkg::ID_W-1:0]   id_ff;
   logic                       kind_ff;
   logic [stt_pkg::TICK_W-1:0] ivl_ff;
   logic [stt_pkg::TICK_W-1:0] now_ff;

   // slot flags and count
   logic [SLOT_COUNT-1:0] occupied_ff, occupied_in;
   logic [SLOT_COUNT-1:0] running_ff, running_in;
   logic [SLOT_COUNT-1:0] repeating_ff, repeating_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [stt_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [stt_pkg::SLOT_W-1:0]    rsp_slot_ff;
   logic                          rsp_last_ff;
   stt_pkg::status_type           rsp_status_in;
   logic [stt_pkg::SLOT_W-1:0]    rsp_slot_in;
   logic                          rsp_last_in;
   logic                          rsp_load;

   // RAM ports
   logic                        start_we, period_we;
   logic [IDX_W-1:0]            start_wa;
   logic [stt_pkg::TICK_W-1:0]  start_wd;
   logic [stt_pkg::TICK_W-1:0]  start_rd, period_rd;

   // misc decode
   logic                        accept;
   logic                        out_free;
   logic                        idx_last;
   logic                        table_full;
   logic                        id_ok;
   logic [IDX_W-1:0]            id_idx;
   logic [IDX_W-1:0]            free_idx;
   logic [stt_pkg::TICK_W-1:0]  deadline;
   logic                        hit_run;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == stt_pkg::ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign idx_last     = (idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign table_full   = (count_ff == CNT_W'(SLOT_COUNT));
   assign id_ok        = (32'(id_ff) < SLOT_COUNT);
   assign id_idx       = IDX_W'(id_ff);

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!occupied_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   // shared add-and-compare unit: start + period against the current tick
   assign deadline = start_rd + period_rd;
   assign hit_run  = running_ff[idx_ff] && (deadline == now_ff);

   stt_ram #(.WIDTH(stt_pkg::TICK_W), .DEPTH(SLOT_COUNT)) u_start_ram (
      .clock   (clock),
      .wr_en   (start_we),
      .wr_addr (start_wa),
      .wr_data (start_wd),
      .rd_addr (idx_ff),
      .rd_data (start_rd)
   );

   stt_ram #(.WIDTH(stt_pkg::TICK_W), .DEPTH(SLOT_COUNT)) u_period_ram (
      .clock   (clock),
      .wr_en   (period_we),
      .wr_addr (free_idx),
      .wr_data (ivl_ff),
      .rd_addr (idx_ff),
      .rd_data (period_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stt_pkg::ST_IDLE: begin
            if (accept) state_in = stt_pkg::ST_EXEC;
         end
         stt_pkg::ST_EXEC: begin
            if (op_ff == stt_pkg::OP_TICK) state_in = stt_pkg::ST_SCAN_ADDR;
            else if (out_free)             state_in = stt_pkg::ST_IDLE;
         end
         stt_pkg::ST_SCAN_ADDR: begin
            if (running_ff[idx_ff]) state_in = stt_pkg::ST_SCAN_EVAL;
            else if (idx_last)      state_in = stt_pkg::ST_SCAN_END;
         end
         stt_pkg::ST_SCAN_EVAL: begin
            if (hit_run && !out_free) state_in = stt_pkg::ST_SCAN_EVAL;
            else if (idx_last)        state_in = stt_pkg::ST_SCAN_END;
            else                      state_in = stt_pkg::ST_SCAN_ADDR;
         end
         stt_pkg::ST_SCAN_END: begin
            if (out_free) state_in = stt_pkg::ST_IDLE;
         end
         default: state_in = stt_pkg::ST_IDLE;
      endcase
   end

   // outputs: slot updates, RAM writes, response load
   always_comb begin
      occupied_in   = occupied_ff;
      running_in    = running_ff;
      repeating_in  = repeating_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_load      = 1'b0;
      rsp_status_in = stt_pkg::STS_DONE;
      rsp_slot_in   = '0;
      rsp_last_in   = 1'b1;
      start_we      = 1'b0;
      start_wa      = idx_ff;
      start_wd      = deadline;
      period_we     = 1'b0;

      case (state_ff)
         stt_pkg::ST_IDLE: begin
            if (accept) idx_in = '0;
         end
         stt_pkg::ST_EXEC: begin
            if (op_ff != stt_pkg::OP_TICK && out_free) begin
               rsp_load = 1'b1;
               case (op_ff)
                  stt_pkg::OP_CREATE: begin
                     if (!table_full) begin
                        occupied_in[free_idx]  = 1'b1;
                        running_in[free_idx]   = 1'b0;
                        repeating_in[free_idx] = kind_ff;
                        count_in      = count_ff + CNT_W'(1);
                        start_we      = 1'b1;
                        start_wa      = free_idx;
                        start_wd      = now_ff;
                        period_we     = 1'b1;
                        rsp_status_in = stt_pkg::STS_CREATED;
                        rsp_slot_in   = stt_pkg::SLOT_W'(free_idx);
                     end else begin
                        rsp_status_in = stt_pkg::STS_FULL;
                     end
                  end
                  stt_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = stt_pkg::STS_EMPTY;
                     end else if (id_ok && occupied_ff[id_idx]) begin
                        occupied_in[id_idx]  = 1'b0;
                        running_in[id_idx]   = 1'b0;
                        repeating_in[id_idx] = 1'b0;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  stt_pkg::OP_START: begin
                     if (id_ok && occupied_ff[id_idx]) begin
                        running_in[id_idx] = 1'b1;
                        start_we = 1'b1;
                        start_wa = id_idx;
                        start_wd = now_ff;
                     end
                  end
                  stt_pkg::OP_STOP: begin
                     // stored start is dead while stopped; start rewrites it
                     if (id_ok) running_in[id_idx] = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         stt_pkg::ST_SCAN_ADDR: begin
            if (!running_ff[idx_ff] && !idx_last) idx_in = idx_ff + IDX_W'(1);
         end
         stt_pkg::ST_SCAN_EVAL: begin
            if (hit_run) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = stt_pkg::STS_FIRED;
                  rsp_slot_in   = stt_pkg::SLOT_W'(idx_ff);
                  rsp_last_in   = 1'b0;
                  if (repeating_ff[idx_ff]) start_we = 1'b1;
                  else                      running_in[idx_ff] = 1'b0;
                  if (!idx_last) idx_in = idx_ff + IDX_W'(1);
               end
            end else if (!idx_last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         stt_pkg::ST_SCAN_END: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = stt_pkg::STS_SCAN_END;
            end
         end
         default: ;
      endcase

      if (rsp_load)          rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stt_pkg::ST_IDLE;
         idx_ff       <= '0;
         occupied_ff  <= '0;
         running_ff   <= '0;
         repeating_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         occupied_ff  <= occupied_in;
         running_ff   <= running_in;
         repeating_ff <= repeating_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_ch.operation;
         id_ff   <= req_ch.timer_id;
         kind_ff <= req_ch.timer_kind;
         ivl_ff  <= req_ch.interval;
         now_ff  <= req_ch.now;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.slot   = rsp_slot_ff;
   assign rsp_ch.last   = rsp_last_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(occupied_ff) == int'(count_ff))
      else $error("active count out of step with occupied slots");

   a_running_occupied: assert property (@(posedge clock) disable iff (reset)
      (running_ff & ~occupied_ff) == '0)
      else $error("free slot marked running");

   a_scan_end_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stt_pkg::ST_SCAN_END && out_free) |=>
         (rsp_valid_ff && rsp_last_ff &&
          rsp_status_ff == stt_pkg::STS_SCAN_END))
      else $error("scan did not close with a final scan-end response");

   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == stt_pkg::STS_FIRED) |-> !rsp_last_ff)
      else $error("fired response flagged as last");

   a_oneshot_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stt_pkg::ST_SCAN_EVAL && hit_run && out_free &&
       !repeating_ff[idx_ff]) |=> !running_ff[$past(idx_ff)])
      else $error("one-shot timer still running after firing");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the software timer table
// Sends create, delete, start, stop, tick and spare-code requests in random
// bursts while the response side stalls on its own pattern. A table tracker
// keeps its own copy of the slots, works out the responses of every accepted
// request and checks each response in order, field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [stt_pkg::OP_W-1:0]   operation;
   logic [stt_pkg::ID_W-1:0]   timer_id;
   logic                       timer_kind;
   logic [stt_pkg::TICK_W-1:0] interval;
   logic [stt_pkg::TICK_W-1:0] now;
} timer_request_type;

typedef struct packed {
   stt_pkg::status_type        status;
   logic [stt_pkg::SLOT_W-1:0] slot;
   logic                       last;
} timer_response_type;

class timer_table_tracker;
   localparam int SLOTS = 16;

   bit                         occupied[SLOTS];
   bit                         running[SLOTS];
   bit                         repeating[SLOTS];
   logic [stt_pkg::TICK_W-1:0] start_tick[SLOTS];
   logic [stt_pkg::TICK_W-1:0] period[SLOTS];
   int unsigned                active_count;
   timer_response_type         pending_responses[$];
   int unsigned                accepted;
   int unsigned                error_count;

   function new();
      for (int s = 0; s < SLOTS; s++) clear_slot(s);
      active_count = 0;
      accepted     = 0;
      error_count  = 0;
   endfunction

   function void clear_slot(int s);
      occupied[s]   = 1'b0;
      running[s]    = 1'b0;
      repeating[s]  = 1'b0;
      start_tick[s] = '0;
      period[s]     = '0;
   endfunction

   function void add_response(stt_pkg::status_type st, int s, logic last);
      timer_response_type r;
      r.status = st;
      r.slot   = stt_pkg::SLOT_W'(s);
      r.last   = last;
      pending_responses.push_back(r);
   endfunction

   // Apply one accepted request to the tracked table and queue its responses.
   function void take_request(timer_request_type rq);
      logic [stt_pkg::TICK_W-1:0] due;
      bit                         found;
      int                         s;
      accepted++;
      case (rq.operation)
         stt_pkg::OP_CREATE: begin
            found = 1'b0;
            if (active_count < SLOTS) begin
               for (s = 0; s < SLOTS && !found; s++) begin
                  if (!occupied[s]) begin
                     occupied[s]   = 1'b1;
                     running[s]    = 1'b0;
                     repeating[s]  = rq.timer_kind;
                     start_tick[s] = rq.now;
                     period[s]     = rq.interval;
                     active_count++;
                     add_response(stt_pkg::STS_CREATED, s, 1'b1);
                     found = 1'b1;
                  end
               end
            end
            if (!found) add_response(stt_pkg::STS_FULL, 0, 1'b1);
         end
         stt_pkg::OP_DELETE: begin
            if (active_count == 0) begin
               add_response(stt_pkg::STS_EMPTY, 0, 1'b1);
            end else begin
               // deleting a free slot leaves the count alone
               if (occupied[rq.timer_id]) begin
                  clear_slot(rq.timer_id);
                  active_count--;
               end
               add_response(stt_pkg::STS_DONE, 0, 1'b1);
            end
         end
         stt_pkg::OP_START: begin
            if (occupied[rq.timer_id]) begin
               running[rq.timer_id]    = 1'b1;
               start_tick[rq.timer_id] = rq.now;
            end
            add_response(stt_pkg::STS_DONE, 0, 1'b1);
         end
         stt_pkg::OP_STOP: begin
            running[rq.timer_id]    = 1'b0;
            start_tick[rq.timer_id] = '0;
            add_response(stt_pkg::STS_DONE, 0, 1'b1);
         end
         stt_pkg::OP_TICK: begin
            for (s = 0; s < SLOTS; s++) begin
               due = start_tick[s] + period[s];
               if (running[s] && due == rq.now) begin
                  add_response(stt_pkg::STS_FIRED, s, 1'b0);
                  if (repeating[s]) start_tick[s] = due;
                  else running[s] = 1'b0;
               end
            end
            add_response(stt_pkg::STS_SCAN_END, 0, 1'b1);
         end
         default: add_response(stt_pkg::STS_DONE, 0, 1'b1);
      endcase
   endfunction

   task report(string msg);
      if (error_count < 50) $display("[%0t] MISMATCH %s", $time, msg);
      error_count++;
   endtask

   task match_response(timer_response_type got);
      timer_response_type want;
      if (pending_responses.size() == 0) begin
         report($sformatf("response with nothing pending: status %0d slot %0d last %0d",
                          got.status, got.slot, got.last));
      end else begin
         want = pending_responses.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.slot !== want.slot)
            report($sformatf("slot %0d, want %0d (status %0d)",
                             got.slot, want.slot, want.status));
         if (got.last !== want.last)
            report($sformatf("last %0d, want %0d (status %0d)",
                             got.last, want.last, want.status));
      end
   endtask
endclass

module testbench;

   localparam int SLOT_COUNT   = 16;
   localparam int RANDOM_ITEMS = 370;
   // random part cycles through balanced, fill-heavy and drain-heavy phases
   localparam int PHASE_LEN    = 60;
   // one long receiver hold-off, started once this many requests got in
   localparam int HOLD_AFTER   = 120;
   localparam int HOLD_CYCLES  = 300;
   // quiet wait after the last response, sized to a tick scan with 16 slots
   localparam int DRAIN_CYCLES = 40;
   // slowest correct run is roughly 400 requests, each with up to 17 responses
   // under the worst stall, plus gaps and the hold-off, well below this limit
   localparam int CYCLE_LIMIT  = 300000;

   // operation codes the block does not define; answered with done
   localparam logic [stt_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [stt_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [stt_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

   // cumulative thresholds (of 100): create, delete, start, stop, tick;
   // whatever is left goes to spare codes
   localparam int OP_MIX [3][5] = '{'{15, 25, 45, 52, 97},
                                    '{45, 50, 70, 73, 98},
                                    '{ 5, 45, 55, 63, 98}};

   logic clock;
   logic reset = 1'b1;

   stt_req_if req_ch();
   stt_rsp_if rsp_ch();

   timer_table_tracker tracker = new();

   int                         burst_left = 0;
   logic [stt_pkg::TICK_W-1:0] tick_base  = '0;
   int                         cycle_count;

   software_timer_table #(
      .SLOT_COUNT(SLOT_COUNT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: a hang or lost response ends here.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   function automatic timer_request_type build_request(
         logic [stt_pkg::OP_W-1:0] op, int id, bit kind,
         logic [stt_pkg::TICK_W-1:0] ivl, logic [stt_pkg::TICK_W-1:0] now);
      timer_request_type rq;
      rq.operation  = op;
      rq.timer_id   = stt_pkg::ID_W'(id);
      rq.timer_kind = kind;
      rq.interval   = ivl;
      rq.now        = now;
      return rq;
   endfunction

   // Offer one request and hold it until taken. Requests go out in bursts;
   // between bursts valid drops. Inputs only move at the falling edge, so a
   // request kept valid gets just one write per step.
   task automatic drive_request(timer_request_type rq);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
         end
         // now and then a long burst, so stretches without idling show up
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
      @(negedge clock);
      req_ch.valid      = 1'b1;
      req_ch.operation  = rq.operation;
      req_ch.timer_id   = rq.timer_id;
      req_ch.timer_kind = rq.timer_kind;
      req_ch.interval   = rq.interval;
      req_ch.now        = rq.now;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.take_request(rq);
      burst_left--;
   endtask

   // Random request shaped on the current table contents: ids mostly hit
   // live slots, intervals are mostly short, and ticks mostly land on the
   // running tick count or right on a running slot's deadline so timers
   // actually fire, several per scan at times.
   function automatic timer_request_type next_random_request(int idx);
      timer_request_type rq;
      int unsigned       live[$];
      int unsigned       armed[$];
      int unsigned       pick;
      int unsigned       phase;
      int unsigned       roll;
      int                s;
      phase         = (idx / PHASE_LEN) % 3;
      rq.timer_id   = stt_pkg::ID_W'($urandom_range(0, 15));
      rq.timer_kind = 1'($urandom_range(0, 1));
      rq.interval   = $urandom;
      rq.now        = $urandom;
      for (s = 0; s < SLOT_COUNT; s++) begin
         if (tracker.occupied[s]) live.push_back(s);
         if (tracker.running[s]) armed.push_back(s);
      end
      if (live.size() != 0 && $urandom_range(0, 99) < 85)
         rq.timer_id = stt_pkg::ID_W'(live[$urandom_range(0, live.size() - 1)]);

      roll = $urandom_range(0, 99);
      if (roll < OP_MIX[phase][0]) begin
         rq.operation = stt_pkg::OP_CREATE;
         rq.now       = tick_base;
         roll = $urandom_range(0, 9);
         if (roll < 6) rq.interval = $urandom_range(0, 6);
         else if (roll < 8) rq.interval = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end else if (roll < OP_MIX[phase][1]) begin
         rq.operation = stt_pkg::OP_DELETE;
      end else if (roll < OP_MIX[phase][2]) begin
         rq.operation = stt_pkg::OP_START;
         rq.now       = tick_base;
      end else if (roll < OP_MIX[phase][3]) begin
         rq.operation = stt_pkg::OP_STOP;
      end else if (roll < OP_MIX[phase][4]) begin
         rq.operation = stt_pkg::OP_TICK;
         roll = $urandom_range(0, 9);
         if (roll >= 5 && roll < 9 && armed.size() != 0) begin
            pick   = armed[$urandom_range(0, armed.size() - 1)];
            rq.now = tracker.start_tick[pick] + tracker.period[pick];
         end else if (roll < 9) begin
            tick_base += $urandom_range(0, 2);
            rq.now     = tick_base;
         end
      end else begin
         rq.operation = OP_SPARE_5 + stt_pkg::OP_W'($urandom_range(0, 2));
      end
      return rq;
   endfunction

   initial begin : stimulus
      int i;
      req_ch.valid      = 1'b0;
      req_ch.operation  = stt_pkg::OP_CREATE;
      req_ch.timer_id   = '0;
      req_ch.timer_kind = 1'b0;
      req_ch.interval   = '0;
      req_ch.now        = '0;

      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed part ---
      // empty table: delete reports empty
      drive_request(build_request(stt_pkg::OP_DELETE, 0, 1'b0, 0, 0));
      // stop and start on free slots are harmless
      drive_request(build_request(stt_pkg::OP_STOP, 15, 1'b1, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF));
      drive_request(build_request(stt_pkg::OP_START, 3, 1'b0, 0, 7));
      // undefined codes
      drive_request(build_request(OP_SPARE_5, 0, 1'b0, 0, 0));
      drive_request(build_request(OP_SPARE_6, 9, 1'b1, 1, 1));
      drive_request(build_request(OP_SPARE_7, 15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // scan with nothing running: only the scan end
      drive_request(build_request(stt_pkg::OP_TICK, 0, 1'b0, 0, 0));
      // slot 0: one-shot, max interval; slot 1: repeating, zero interval;
      // slot 2: repeating, interval 3
      drive_request(build_request(stt_pkg::OP_CREATE, 0, 1'b0, 32'hFFFF_FFFF,
                                  32'hFFFF_FFF0));
      drive_request(build_request(stt_pkg::OP_CREATE, 0, 1'b1, 0, 5));
      drive_request(build_request(stt_pkg::OP_CREATE, 0, 1'b1, 3, 9));
      // slot 0 deadline wraps to 0xFFFFFFEF, slot 2 wraps to 1
      drive_request(build_request(stt_pkg::OP_START, 0, 1'b0, 0, 32'hFFFF_FFF0));
      drive_request(build_request(stt_pkg::OP_START, 1, 1'b0, 0, 100));
      drive_request(build_request(stt_pkg::OP_START, 2, 1'b0, 0, 32'hFFFF_FFFE));
      // zero interval fires each time now equals the start, start stays put
      drive_request(build_request(stt_pkg::OP_TICK, 0, 1'b0, 0, 100));
      drive_request(build_request(stt_pkg::OP_TICK, 0, 1'b0, 0, 100));
      // repeating slot across the wrap, then one period later
      drive_request(build_request(stt_pkg::OP_TICK, 0, 1'b0, 0, 1));
      drive_request(build_request(stt_pkg::OP_TICK, 0, 1'b0, 0, 4));
      // one-shot fires once and then stays quiet
      drive_request(build_request(stt_pkg::OP_TICK, 0, 1'b0, 0, 32'hFFFF_FFEF));
      drive_request(build_request(stt_pkg::OP_TICK, 0, 1'b0, 0, 32'hFFFF_FFEF));
      // delete of a free slot on a non-empty table keeps the count
      drive_request(build_request(stt_pkg::OP_DELETE, 5, 1'b0, 0, 0));
      drive_request(build_request(stt_pkg::OP_STOP, 1, 1'b0, 0, 0));
      drive_request(build_request(stt_pkg::OP_DELETE, 0, 1'b0, 0, 0));
      // lowest free slot is taken again
      drive_request(build_request(stt_pkg::OP_CREATE, 0, 1'b0, 2, 50));

      // --- random part, starting close to the 32-bit wrap of the tick ---
      tick_base = 32'hFFFF_FF80;
      for (i = 0; i < RANDOM_ITEMS; i++) drive_request(next_random_request(i));

      @(negedge clock);
      req_ch.valid = 1'b0;

      // wait for everything outstanding, then a scan's worth of quiet so a
      // stray extra response would still be caught
      while (tracker.pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Ready runs high for a while, then stalls. Once, after enough requests
   // went in, ready stays low for a long stretch while the sender keeps
   // offering, so the response register and sequencer back up and the
   // request side must stall.
   initial begin : response_sink
      int  run_len;
      int  stall_len;
      bit  held_off;
      held_off     = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         if (!held_off && tracker.accepted >= HOLD_AFTER) begin
            held_off = 1'b1;
            @(negedge clock);
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 16);
         repeat (run_len) begin
            @(negedge clock);
            rsp_ch.ready = 1'b1;
         end
         stall_len = $urandom_range(1, 5);
         repeat (stall_len) begin
            @(negedge clock);
            rsp_ch.ready = 1'b0;
         end
      end
   end

   // Every response taken at a rising edge goes against the oldest one due.
   always @(posedge clock) begin
      timer_response_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.status = stt_pkg::status_type'(rsp_ch.status);
         got.slot   = rsp_ch.slot;
         got.last   = rsp_ch.last;
         tracker.match_response(got);
      end
   end

endmodule
